FILE: src/sfs_pkg.sv
// shared types, constants and register codes for the sor flow sweep core
// no dependencies
package sfs_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX        = 2'd3;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd1024;
    localparam logic [31:0] SMOOTH_RST       = 32'd65536;
    localparam logic [14:0] RELAX_RST        = 15'd16384;
    localparam logic [15:0] RELAX_ONE        = 16'd16384;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W   = 52;
    localparam int DIV_D_W   = 36;
    localparam int DIV_Q_W   = 48;
    localparam int DIV_STEPS = DIV_N_W + 16;

    typedef struct packed {
        logic        op;
        logic [31:0] j11;
        logic [31:0] j12;
        logic [31:0] j13;
        logic [31:0] j22;
        logic [31:0] j23;
        logic [31:0] u_old;
        logic [31:0] v_old;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] u_new;
        logic [31:0] v_new;
        logic        frame_end;
        logic        fault;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] j11;
        logic [31:0] j12;
        logic [31:0] j13;
        logic [31:0] j22;
        logic [31:0] j23;
        logic [31:0] v;
        logic [31:0] u;
    } pend_word_t;

    typedef struct packed {
        logic start;
        logic keep;
        logic b_signed;
    } mul_ctrl_t;

endpackage

FILE: src/sfs_mul.sv
// bit-serial shift-and-add multiplier, one bit of b per cycle, optional accumulate
// depends on sfs_pkg
module sfs_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sfs_pkg::mul_ctrl_t               ctrl,
    input  logic [sfs_pkg::MUL_A_W-1:0]      a,
    input  logic [sfs_pkg::MUL_B_W-1:0]      b,
    output logic                             done,
    output logic [sfs_pkg::MUL_P_W-1:0]      prod
);

    localparam int AW = sfs_pkg::MUL_A_W;
    localparam int BW = sfs_pkg::MUL_B_W;
    localparam int PW = sfs_pkg::MUL_P_W;
    localparam int CW = $clog2(BW);

    logic [PW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          bs_reg;
    logic          last;
    logic [PW-1:0] addend;

    assign last = cnt_reg == CW'(BW - 1);

    always_comb
    begin
        if (b_reg[0])
        begin
            addend = (last && bs_reg) ? (~a_reg + PW'(1)) : a_reg;
        end
        else
        begin
            addend = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg  <= {{(PW-AW){a[AW-1]}}, a};
            b_reg  <= b;
            bs_reg <= ctrl.b_signed;
            if (!ctrl.keep)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend;
            a_reg   <= {a_reg[PW-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: src/sfs_div.sv
// restoring divider, one quotient bit per cycle, quotient of num*2^16/den clamped to 2^47
// depends on sfs_pkg
module sfs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sfs_pkg::DIV_N_W-1:0]    num,
    input  logic [sfs_pkg::DIV_D_W-1:0]    den,
    output logic                           done,
    output logic [sfs_pkg::DIV_Q_W-1:0]    mag
);

    localparam int NW = sfs_pkg::DIV_N_W;
    localparam int DW = sfs_pkg::DIV_D_W;
    localparam int QW = sfs_pkg::DIV_Q_W;
    localparam int SW = sfs_pkg::DIV_STEPS;
    localparam int CW = $clog2(SW);

    logic [SW-1:0] dvd_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] q_reg;
    logic          ovf_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic          last;

    assign trial = {rem_reg, dvd_reg[SW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};
    assign last  = cnt_reg == CW'(SW - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, 16'b0};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[QW-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[QW-1];
            dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign mag  = (ovf_reg || q_reg[QW-1]) ? {1'b1, {(QW-1){1'b0}}} : q_reg;

endmodule

FILE: src/sor_flow_sweep_core.sv
// sor flow sweep core: one in-place over-relaxation sweep over a flow field, raster order
// a pixel with a result runs, per component, four 32-step serial multiplies and one 68-step
// serial division (zero denominator: two multiplies only), plus read and write-back steps
// first-row pixels skip the solve, ignored drain beats stay idle; one beat in flight at a time
// results lag one row; the output register lets the next beat enter while a result waits
// reset (rst_n low, async) restores register defaults and positions; row stores are not cleared
module sor_flow_sweep_core #(
    parameter int MAX_WIDTH  = sfs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sfs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sfs_pkg::in_beat_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sfs_pkg::out_beat_t                  out_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = sfs_pkg::MUL_A_W;
    localparam int BW = sfs_pkg::MUL_B_W;
    localparam int PW = sfs_pkg::MUL_P_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD0    = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_SUM    = 4'd3;
    localparam logic [3:0] S_MUL_T  = 4'd4;
    localparam logic [3:0] S_WAIT_T = 4'd5;
    localparam logic [3:0] S_MUL_P  = 4'd6;
    localparam logic [3:0] S_WAIT_P = 4'd7;
    localparam logic [3:0] S_CHK    = 4'd8;
    localparam logic [3:0] S_WAIT_D = 4'd9;
    localparam logic [3:0] S_MUL_C  = 4'd10;
    localparam logic [3:0] S_WAIT_C = 4'd11;
    localparam logic [3:0] S_MUL_Q  = 4'd12;
    localparam logic [3:0] S_WAIT_Q = 4'd13;
    localparam logic [3:0] S_NEXT   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    // configuration
    logic [10:0] fw_reg;
    logic [10:0] fh_reg;
    logic [31:0] sw_reg;
    logic [14:0] rf_reg;
    logic [31:0] fw_ext;
    logic [31:0] fh_ext;
    logic [CW:0]   eff_w;
    logic [RW-1:0] eff_h;
    logic [RW-1:0] h_last;

    // positions
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] in_c_n;
    logic [RW-1:0] in_r_n;
    logic [CW-1:0] out_c_n;
    logic [RW-1:0] out_r_n;
    logic [CW:0]   x_inc;
    logic [CW:0]   oc_inc;
    logic [RW-1:0] y_inc;
    logic          x_last;
    logic          oc_last;
    logic          y_last;
    logic          acc_in;
    logic          is_drain;
    logic          serve_drain;

    logic [3:0] state_reg, state_next;
    logic       comp_reg,  comp_next;

    // job
    logic [CW-1:0]       job_col;
    logic                job_up;
    logic                job_left;
    logic                job_right;
    logic                job_down;
    logic                job_fend;
    logic                job_pwr;
    logic                job_solve;
    logic [63:0]         down_reg;
    sfs_pkg::pend_word_t pend_wdata;

    // row stores
    sfs_pkg::pend_word_t pend_mem [MAX_WIDTH];
    logic [63:0]         upd_mem  [MAX_WIDTH];
    sfs_pkg::pend_word_t pend_rd;
    logic [63:0]         upd_rd;
    logic [CW-1:0]       pend_raddr;
    logic [CW-1:0]       upd_raddr;

    // datapath
    sfs_pkg::pend_word_t cur_reg;
    logic [63:0]  up_reg;
    logic [33:0]  su_reg;
    logic [33:0]  sv_reg;
    logic [34:0]  coef_reg;
    logic [51:0]  t_reg;
    logic [51:0]  n_reg;
    logic [35:0]  d_reg;
    logic [AW-1:0] q_reg;
    logic [31:0]  u_res_reg;
    logic [31:0]  v_res_reg;
    logic         fault_reg;

    logic [33:0]  su_sum;
    logic [33:0]  sv_sum;
    logic [2:0]   nb_cnt;
    logic [34:0]  coef;
    logic [31:0]  centre;
    logic [31:0]  jdiag;
    logic [31:0]  jrhs;
    logic [33:0]  s_cur;
    logic [31:0]  other;
    logic [47:0]  p_val;
    logic [51:0]  n_val;
    logic [35:0]  d_val;
    logic [51:0]  n_mag;
    logic [35:0]  d_mag;
    logic [AW-1:0] q_val;
    logic [15:0]  rb16;
    logic [66:0]  res67;
    logic [31:0]  res_sat;
    logic         res_ovf;

    sfs_pkg::mul_ctrl_t mul_ctrl;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          mul_done;
    logic [PW-1:0] mul_prod;
    logic          div_start;
    logic          div_done;
    logic [sfs_pkg::DIV_Q_W-1:0] div_mag;

    sfs_pkg::out_beat_t out_data_reg;
    logic               out_valid_reg;
    logic               out_load;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= sfs_pkg::FRAME_WIDTH_RST;
            fh_reg <= sfs_pkg::FRAME_HEIGHT_RST;
            sw_reg <= sfs_pkg::SMOOTH_RST;
            rf_reg <= sfs_pkg::RELAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfs_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_data[10:0];
                sfs_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_data[10:0];
                sfs_pkg::CFG_SMOOTH:       sw_reg <= cfg_data;
                sfs_pkg::CFG_RELAX:        rf_reg <= cfg_data[14:0];
            endcase
        end
    end

    assign fw_ext = {21'b0, fw_reg};
    assign fh_ext = {21'b0, fh_reg};

    always_comb
    begin
        if (fw_reg == 11'd0)
        begin
            eff_w = (CW+1)'(1);
        end
        else if (fw_ext > 32'(MAX_WIDTH))
        begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext[CW:0];
        end
        if (fh_reg == 11'd0)
        begin
            eff_h = RW'(1);
        end
        else if (fh_ext > 32'(MAX_HEIGHT))
        begin
            eff_h = RW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = fh_ext[RW-1:0];
        end
    end

    assign h_last = eff_h - RW'(1);

    // position bookkeeping at accept
    always_comb
    begin
        if ({1'b0, in_col_reg} >= eff_w || in_row_reg >= eff_h)
        begin
            in_c_n = '0;
            in_r_n = '0;
        end
        else
        begin
            in_c_n = in_col_reg;
            in_r_n = in_row_reg;
        end
        if ({1'b0, out_col_reg} >= eff_w || out_row_reg >= eff_h)
        begin
            out_c_n = '0;
            out_r_n = '0;
        end
        else
        begin
            out_c_n = out_col_reg;
            out_r_n = out_row_reg;
        end
    end

    assign x_inc       = {1'b0, in_c_n} + (CW+1)'(1);
    assign oc_inc      = {1'b0, out_c_n} + (CW+1)'(1);
    assign y_inc       = in_r_n + RW'(1);
    assign x_last      = x_inc >= eff_w;
    assign oc_last     = oc_inc >= eff_w;
    assign y_last      = y_inc >= eff_h;
    assign acc_in      = in_valid && in_ready;
    assign is_drain    = in_data.op == sfs_pkg::OP_DRAIN;
    assign serve_drain = (in_c_n == '0) && (in_r_n == '0) && (out_r_n == h_last);

    always_comb
    begin
        state_next   = state_reg;
        comp_next    = comp_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    in_col_next  = in_c_n;
                    in_row_next  = in_r_n;
                    out_col_next = out_c_n;
                    out_row_next = out_r_n;
                    if (is_drain)
                    begin
                        if (serve_drain)
                        begin
                            state_next = S_RD0;
                            if (oc_last)
                            begin
                                out_col_next = '0;
                                out_row_next = '0;
                            end
                            else
                            begin
                                out_col_next = oc_inc[CW-1:0];
                            end
                        end
                    end
                    else
                    begin
                        if (in_r_n != '0)
                        begin
                            state_next = S_RD0;
                            if (x_last)
                            begin
                                out_col_next = '0;
                                out_row_next = in_r_n;
                            end
                            else
                            begin
                                out_col_next = x_inc[CW-1:0];
                                out_row_next = in_r_n - RW'(1);
                            end
                        end
                        else
                        begin
                            state_next = S_DONE;
                            if (in_c_n == '0)
                            begin
                                out_col_next = '0;
                                out_row_next = '0;
                            end
                        end
                        if (x_last)
                        begin
                            in_col_next = '0;
                            in_row_next = y_last ? '0 : y_inc;
                        end
                        else
                        begin
                            in_col_next = x_inc[CW-1:0];
                        end
                    end
                end
            end
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_SUM;
            S_SUM:
            begin
                state_next = S_MUL_T;
                comp_next  = 1'b0;
            end
            S_MUL_T:  state_next = S_WAIT_T;
            S_WAIT_T: state_next = mul_done ? S_MUL_P : S_WAIT_T;
            S_MUL_P:  state_next = S_WAIT_P;
            S_WAIT_P: state_next = mul_done ? S_CHK : S_WAIT_P;
            S_CHK:    state_next = (d_reg == '0) ? S_NEXT : S_WAIT_D;
            S_WAIT_D: state_next = div_done ? S_MUL_C : S_WAIT_D;
            S_MUL_C:  state_next = S_WAIT_C;
            S_WAIT_C: state_next = mul_done ? S_MUL_Q : S_WAIT_C;
            S_MUL_Q:  state_next = S_WAIT_Q;
            S_WAIT_Q: state_next = mul_done ? S_NEXT : S_WAIT_Q;
            S_NEXT:
            begin
                if (!comp_reg)
                begin
                    comp_next  = 1'b1;
                    state_next = S_MUL_T;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!job_solve || !out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            comp_reg    <= 1'b0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            comp_reg    <= comp_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    // job capture
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            if (is_drain)
            begin
                job_col   <= out_c_n;
                job_up    <= h_last != '0;
                job_left  <= out_c_n != '0;
                job_right <= !oc_last;
                job_down  <= 1'b0;
                job_fend  <= oc_last;
                job_pwr   <= 1'b0;
                job_solve <= 1'b1;
            end
            else
            begin
                job_col   <= in_c_n;
                job_up    <= in_r_n > RW'(1);
                job_left  <= in_c_n != '0;
                job_right <= !x_last;
                job_down  <= 1'b1;
                job_fend  <= 1'b0;
                job_pwr   <= 1'b1;
                job_solve <= in_r_n != '0;
            end
            down_reg       <= {in_data.v_old, in_data.u_old};
            pend_wdata.j11 <= in_data.j11;
            pend_wdata.j12 <= in_data.j12;
            pend_wdata.j13 <= in_data.j13;
            pend_wdata.j22 <= in_data.j22;
            pend_wdata.j23 <= in_data.j23;
            pend_wdata.v   <= in_data.v_old;
            pend_wdata.u   <= in_data.u_old;
        end
    end

    // row stores
    assign pend_raddr = (state_reg == S_RD0) ? job_col : job_col + CW'(1);
    assign upd_raddr  = (state_reg == S_RD0) ? job_col : job_col - CW'(1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD0 || state_reg == S_RD1)
        begin
            pend_rd <= pend_mem[pend_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD0 || state_reg == S_RD1)
        begin
            upd_rd <= upd_mem[upd_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && job_pwr)
        begin
            pend_mem[job_col] <= pend_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && job_solve)
        begin
            upd_mem[job_col] <= {v_res_reg, u_res_reg};
        end
    end

    // neighbour sums
    always_comb
    begin
        su_sum = (job_left  ? {{2{upd_rd[31]}}, upd_rd[31:0]}     : 34'd0)
               + (job_right ? {{2{pend_rd.u[31]}}, pend_rd.u}     : 34'd0)
               + (job_up    ? {{2{up_reg[31]}}, up_reg[31:0]}     : 34'd0)
               + (job_down  ? {{2{down_reg[31]}}, down_reg[31:0]} : 34'd0);
        sv_sum = (job_left  ? {{2{upd_rd[63]}}, upd_rd[63:32]}     : 34'd0)
               + (job_right ? {{2{pend_rd.v[31]}}, pend_rd.v}      : 34'd0)
               + (job_up    ? {{2{up_reg[63]}}, up_reg[63:32]}     : 34'd0)
               + (job_down  ? {{2{down_reg[63]}}, down_reg[63:32]} : 34'd0);
        nb_cnt = 3'(job_left) + 3'(job_right) + 3'(job_up) + 3'(job_down);
        unique case (nb_cnt)
            3'd0:    coef = 35'd0;
            3'd1:    coef = {3'b0, sw_reg};
            3'd2:    coef = {2'b0, sw_reg, 1'b0};
            3'd3:    coef = {2'b0, sw_reg, 1'b0} + {3'b0, sw_reg};
            3'd4:    coef = {1'b0, sw_reg, 2'b0};
            default: coef = 35'd0;
        endcase
    end

    // per-component operands
    assign centre = comp_reg ? cur_reg.v   : cur_reg.u;
    assign jdiag  = comp_reg ? cur_reg.j22 : cur_reg.j11;
    assign jrhs   = comp_reg ? cur_reg.j23 : cur_reg.j13;
    assign s_cur  = comp_reg ? sv_reg      : su_reg;
    assign other  = comp_reg ? u_res_reg   : cur_reg.v;

    assign p_val = mul_prod[63:16];
    assign n_val = t_reg - {{4{p_val[47]}}, p_val} - {{20{jrhs[31]}}, jrhs};
    assign d_val = {1'b0, coef_reg} + {{4{jdiag[31]}}, jdiag};
    assign n_mag = n_reg[51] ? (~n_reg + 52'd1) : n_reg;
    assign d_mag = d_reg[35] ? (~d_reg + 36'd1) : d_reg;
    assign q_val = (n_reg[51] ^ d_reg[35]) ? (~{1'b0, div_mag} + AW'(1)) : {1'b0, div_mag};
    assign rb16  = sfs_pkg::RELAX_ONE - {1'b0, rf_reg};

    assign res67   = mul_prod[80:14];
    assign res_ovf = res67[66:31] != {36{res67[31]}};
    assign res_sat = res_ovf ? (res67[66] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res67[31:0];

    // multiplier operand select
    always_comb
    begin
        mul_ctrl.start    = state_reg == S_MUL_T || state_reg == S_MUL_P
                         || state_reg == S_MUL_C || state_reg == S_MUL_Q;
        mul_ctrl.keep     = state_reg == S_MUL_Q;
        mul_ctrl.b_signed = state_reg == S_MUL_P || state_reg == S_MUL_C;
        unique case (state_reg)
            S_MUL_T:
            begin
                mul_a = {{(AW-34){s_cur[33]}}, s_cur};
                mul_b = sw_reg;
            end
            S_MUL_P:
            begin
                mul_a = {{(AW-32){cur_reg.j12[31]}}, cur_reg.j12};
                mul_b = other;
            end
            S_MUL_C:
            begin
                mul_a = {{(AW-32){centre[31]}}, centre};
                mul_b = {{16{rb16[15]}}, rb16};
            end
            default:
            begin
                mul_a = q_reg;
                mul_b = {17'b0, rf_reg};
            end
        endcase
    end

    assign div_start = state_reg == S_CHK && d_reg != '0;

    sfs_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (mul_ctrl),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .prod (mul_prod)
    );

    sfs_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (n_mag),
        .den  (d_mag),
        .done (div_done),
        .mag  (div_mag)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_RD1:
            begin
                cur_reg <= pend_rd;
                up_reg  <= upd_rd;
            end
            S_SUM:
            begin
                su_reg    <= su_sum;
                sv_reg    <= sv_sum;
                coef_reg  <= coef;
                fault_reg <= 1'b0;
            end
            S_WAIT_T:
            begin
                if (mul_done)
                begin
                    t_reg <= mul_prod[67:16];
                end
            end
            S_WAIT_P:
            begin
                if (mul_done)
                begin
                    n_reg <= n_val;
                    d_reg <= d_val;
                end
            end
            S_CHK:
            begin
                if (d_reg == '0)
                begin
                    fault_reg <= 1'b1;
                    if (comp_reg)
                    begin
                        v_res_reg <= centre;
                    end
                    else
                    begin
                        u_res_reg <= centre;
                    end
                end
            end
            S_WAIT_D:
            begin
                if (div_done)
                begin
                    q_reg <= q_val;
                end
            end
            S_WAIT_Q:
            begin
                if (mul_done)
                begin
                    fault_reg <= fault_reg | res_ovf;
                    if (comp_reg)
                    begin
                        v_res_reg <= res_sat;
                    end
                    else
                    begin
                        u_res_reg <= res_sat;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    assign out_load = state_reg == S_DONE && job_solve && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.u_new     <= u_res_reg;
            out_data_reg.v_new     <= v_res_reg;
            out_data_reg.frame_end <= job_fend;
            out_data_reg.fault     <= fault_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_WAIT_T || state_reg == S_WAIT_P
                   || state_reg == S_WAIT_C || state_reg == S_WAIT_Q))
        else $error("multiplier finished outside a wait step");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_WAIT_D)
        else $error("divider finished outside its wait step");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("solved beat not presented");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(mul_ctrl.start && div_start))
        else $error("multiplier and divider started together");

endmodule
